// ===== hdl/assert_macros.svh =====
// Assertion macros for the block's RTL; nsa_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define NSA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define NSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NSA_ASSERT(lbl, clk, rstn, prop, msg)
`define NSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define NSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/nsa_pkg.sv =====
package nsa_pkg;

    localparam int SLOTS      = 128;
    localparam int NAME_CHARS = 8;
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 7;
    localparam int SLOT_W     = 7;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_CLAIMED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] idx;
    } wr_t;

endpackage

// ===== hdl/named_slot_acquire_release.sv =====
// Table of named shared slots with acquire and release requests.
// Input channel: in_valid, in_stall, kind, name_key, handle. An item is taken at a clock
// edge where in_valid is high and in_stall is low. Output channel: out_valid, out_stall,
// slot, status, one result item per input item, in order.
// An acquire walks a token down a row of slot cells, one cell per cycle, looking for an
// in-use slot with the same name and the lowest free slot. The token passes the start
// register and every cell register; the scan result is then registered, and the emit
// state loads the output register. The next item is taken once the block is back in idle.
// A release, or an acquire refused because the table is full, goes from idle straight to
// the emit state, and the next item is taken once the block is back in idle.
// One item is in work at a time; in_stall is high while it is.
// The result sits in an output register, so a new item is taken while the previous result
// still waits; if the receiver stalls, a finished result waits inside and the input stays
// stalled until the output register is free.
// Reset frees every slot, clears the use count and both channels at once; no clearing pass runs.
module named_slot_acquire_release
    import nsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    name_key,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status
);

    tok_t             chain [0:SLOTS];
    logic [SLOTS-1:0] in_use;
    logic [KEY_W-1:0] key;
    wr_t              wr;

    nsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .name_key  (name_key),
        .handle    (handle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot      (slot),
        .status    (status),
        .in_use    (in_use),
        .tok_tail  (chain[SLOTS]),
        .tok_head  (chain[0]),
        .key       (key),
        .wr        (wr)
    );

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        nsa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(g)),
            .key        (key),
            .wr         (wr),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1]),
            .in_use     (in_use[g])
        );
    end

endmodule

// ===== hdl/nsa_cell.sv =====
module nsa_cell
    import nsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  logic [KEY_W-1:0] key,
    input  wr_t              wr,
    input  tok_t             tok_in,
    output tok_t             tok_out,
    output logic             in_use
);

    logic             in_use_reg;
    logic             in_use_next;
    logic [KEY_W-1:0] name_reg;
    logic [KEY_W-1:0] name_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             sel;
    logic             match;

    always_comb
    begin
        sel   = wr.en && (wr.idx == cell_index);
        match = in_use_reg && (name_reg == key);

        tok_next = tok_in;
        if (tok_in.valid)
        begin
            if (match && !tok_in.hit)
            begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_index;
            end
            if (!in_use_reg && !tok_in.free)
            begin
                tok_next.free     = 1'b1;
                tok_next.free_idx = cell_index;
            end
        end

        in_use_next = in_use_reg;
        name_next   = name_reg;
        if (sel)
        begin
            in_use_next = wr.set;
            name_next   = wr.set ? key : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
    end

    assign tok_out = tok_reg;
    assign in_use  = in_use_reg;

endmodule

// ===== hdl/nsa_ctrl.sv =====
`include "assert_macros.svh"

module nsa_ctrl
    import nsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    name_key,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status,
    input  logic [SLOTS-1:0]    in_use,
    input  tok_t                tok_tail,
    output tok_t                tok_head,
    output logic [KEY_W-1:0]    key,
    output wr_t                 wr
);

    fsm_t              state_reg;
    fsm_t              state_next;
    logic              start_reg;
    logic              start_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    status_t           status_reg;
    status_t           status_next;
    logic              handle_ok;
    logic [IDX_W-1:0]  handle_idx;

    // The name ends at the first zero byte or after the allowed number of bytes.
    function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             keep;
        res  = '0;
        keep = 1'b1;
        for (int i = 0; i < KEY_W / 8; i++)
        begin
            keep = keep && (i < NAME_CHARS) && (k[8*i +: 8] != 8'd0);
            if (keep)
            begin
                res[8*i +: 8] = k[8*i +: 8];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        start_next      = 1'b0;
        key_next        = key_reg;
        cnt_next        = cnt_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        wr              = '0;
        handle_ok       = int'(handle) < SLOTS;
        handle_idx      = IDX_W'(handle);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = S_EMIT;
                    res_slot_next = '0;
                    if (kind == KIND_RELEASE)
                    begin
                        if (handle_ok && in_use[handle_idx])
                        begin
                            wr.en           = 1'b1;
                            wr.set          = 1'b0;
                            wr.idx          = handle_idx;
                            cnt_next        = cnt_reg - CNT_W'(1);
                            res_status_next = ST_RELEASED;
                        end
                        else
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    end
                    else
                    begin
                        key_next = canon_name(name_key);
                        if (cnt_reg == CNT_W'(SLOTS))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            start_next = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (tok_tail.valid)
                begin
                    state_next = S_EMIT;
                    if (tok_tail.hit)
                    begin
                        res_slot_next   = SLOT_W'(tok_tail.hit_idx);
                        res_status_next = ST_FOUND;
                    end
                    else if (tok_tail.free)
                    begin
                        wr.en           = 1'b1;
                        wr.set          = 1'b1;
                        wr.idx          = tok_tail.free_idx;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        res_slot_next   = SLOT_W'(tok_tail.free_idx);
                        res_status_next = ST_CLAIMED;
                    end
                    else
                    begin
                        res_slot_next   = '0;
                        res_status_next = ST_FULL;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = res_slot_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        tok_head       = '0;
        tok_head.valid = start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign status    = status_reg;
    assign key       = key_reg;

    `NSA_ASSERT(a_count_matches, clk, rst_n, $countones(in_use) == int'(cnt_reg), "count differs from slots in use")
    `NSA_ASSERT_IMPL(a_tail_in_scan, clk, rst_n, tok_tail.valid, state_reg == S_SCAN, "scan result outside scan")
    `NSA_ASSERT_IMPL(a_claim_free, clk, rst_n, wr.en && wr.set, !in_use[wr.idx], "claim of a slot in use")
    `NSA_ASSERT_NEXT(a_release_count, clk, rst_n, wr.en && !wr.set, cnt_reg == $past(cnt_reg) - CNT_W'(1), "release did not lower count")

endmodule
